// ===== hw/rtl/srpid_pkg.sv =====
// srpid_pkg: shared types and constants for the slip-ratio PID torque limiter.
// Used by srpid_div, srpid_mac and slip_ratio_pid_torque_limiter; no dependencies.

package srpid_pkg;

   // default sizes
   localparam int SPEED_BITS_DEF    = 12;
   localparam int FRAC_BITS_DEF     = 12;
   localparam int INTEGRAL_BITS_DEF = 24;

   // fixed field widths
   localparam int RATIO_BITS  = 16;
   localparam int GAIN_BITS   = 8;
   localparam int TORQUE_BITS = 10;
   localparam int ERROR_BITS  = 18;
   localparam int DERIV_BITS  = 19;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // register reset values
   localparam logic [RATIO_BITS-1:0]  TARGET_SLIP_RST  = 16'd410;
   localparam logic [TORQUE_BITS-1:0] TORQUE_LIMIT_RST = 10'd100;
   localparam logic [RATIO_BITS-1:0]  RATIO_MAX        = 16'hFFFF;

   // register map
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_TARGET_SLIP  = 3'd0,
      REG_KP_GAIN      = 3'd1,
      REG_KI_GAIN      = 3'd2,
      REG_KD_GAIN      = 3'd3,
      REG_TORQUE_LIMIT = 3'd4
   } reg_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ERROR,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_DRAIN,
      ST_CLAMP,
      ST_DONE
   } state_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic done;
   } div_status_type;

   // multiply-accumulate control from the sequencer
   typedef struct packed {
      logic clear;
      logic op_valid;
   } mac_ctl_type;

endpackage

// ===== hw/rtl/slip_ratio_pid_torque_limiter.sv =====
// slip_ratio_pid_torque_limiter: slip-ratio PID with clamped torque output.
// Drive request: the bit-serial divider, then three passes through one shared multiplier,
// then the clamp; with both front speeds zero the divider is skipped. Hold request: the
// held torque is handed on with no computation. One request in flight; the next is taken
// the cycle after the result is handed on.
// Synchronous reset: registers to defaults, integral, last error and torque to zero.

module slip_ratio_pid_torque_limiter #(
   parameter int SPEED_BITS    = srpid_pkg::SPEED_BITS_DEF,
   parameter int FRAC_BITS     = srpid_pkg::FRAC_BITS_DEF,
   parameter int INTEGRAL_BITS = srpid_pkg::INTEGRAL_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [SPEED_BITS-1:0]                 req_front_right_speed,
   input  logic [SPEED_BITS-1:0]                 req_front_left_speed,
   input  logic [SPEED_BITS-1:0]                 req_rear_right_speed,
   input  logic [SPEED_BITS-1:0]                 req_rear_left_speed,
   input  logic                                  req_drive_active,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [srpid_pkg::TORQUE_BITS-1:0]     rsp_torque_adjust,
   output logic                                  rsp_updated,
   output logic [srpid_pkg::RATIO_BITS-1:0]      rsp_slip_ratio,
   output logic                                  rsp_front_stopped,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [srpid_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [srpid_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int IB   = INTEGRAL_BITS;
   localparam int EB   = srpid_pkg::ERROR_BITS;
   localparam int DB   = srpid_pkg::DERIV_BITS;
   localparam int OPW  = (IB > DB) ? IB : DB;
   localparam int ACCW = OPW + srpid_pkg::GAIN_BITS + 3;
   localparam int QW   = ACCW - FRAC_BITS;
   localparam int TB   = srpid_pkg::TORQUE_BITS;
   localparam int RB   = srpid_pkg::RATIO_BITS;
   localparam int GB   = srpid_pkg::GAIN_BITS;

   // configuration registers
   logic [RB-1:0] target_ff;
   logic [GB-1:0] kp_ff, ki_ff, kd_ff;
   logic [TB-1:0] limit_ff;

   // controller state
   logic signed [IB-1:0] esum_ff, esum_in;
   logic signed [EB-1:0] lerr_ff, lerr_in;
   logic [TB-1:0]        held_ff, held_in;

   // working registers
   srpid_pkg::state_type state_ff, state_in;
   logic [SPEED_BITS:0]  front_ff, front_in;
   logic [SPEED_BITS:0]  rear_ff, rear_in;
   logic [RB-1:0]        ratio_ff, ratio_in;
   logic                 stop_ff, stop_in;
   logic                 upd_ff, upd_in;
   logic signed [EB-1:0] err_ff, err_in;
   logic signed [DB-1:0] deriv_ff, deriv_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [TB-1:0] rsp_torque_ff, rsp_torque_in;
   logic          rsp_upd_ff, rsp_upd_in;
   logic [RB-1:0] rsp_ratio_ff, rsp_ratio_in;
   logic          rsp_stop_ff, rsp_stop_in;

   // shared unit hookups
   srpid_pkg::div_status_type div_status;
   logic [RB-1:0]             div_ratio;
   logic                      div_start;
   srpid_pkg::mac_ctl_type    mac_ctl;
   logic [GB-1:0]             mac_gain;
   logic signed [OPW-1:0]     mac_operand;
   logic signed [ACCW-1:0]    mac_acc;

   // scratch
   logic                 accept;
   logic [SPEED_BITS:0]  front_now;
   logic signed [EB-1:0] err_now;
   logic signed [IB:0]   esum_wide;
   logic [QW-1:0]        q_now;

   srpid_div #(
      .SPEED_BITS (SPEED_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .front_sum (front_ff),
      .rear_sum  (rear_ff),
      .status    (div_status),
      .ratio     (div_ratio)
   );

   srpid_mac #(
      .OPW (OPW)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .gain    (mac_gain),
      .operand (mac_operand),
      .acc     (mac_acc)
   );

   // register writes, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= srpid_pkg::TARGET_SLIP_RST;
         kp_ff     <= '0;
         ki_ff     <= '0;
         kd_ff     <= '0;
         limit_ff  <= srpid_pkg::TORQUE_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            srpid_pkg::REG_TARGET_SLIP:  target_ff <= csr_wdata[RB-1:0];
            srpid_pkg::REG_KP_GAIN:      kp_ff     <= csr_wdata[GB-1:0];
            srpid_pkg::REG_KI_GAIN:      ki_ff     <= csr_wdata[GB-1:0];
            srpid_pkg::REG_KD_GAIN:      kd_ff     <= csr_wdata[GB-1:0];
            srpid_pkg::REG_TORQUE_LIMIT: limit_ff  <= csr_wdata[TB-1:0];
            default: ;
         endcase
      end
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in  = state_ff;
      front_in  = front_ff;
      rear_in   = rear_ff;
      ratio_in  = ratio_ff;
      stop_in   = stop_ff;
      upd_in    = upd_ff;
      err_in    = err_ff;
      deriv_in  = deriv_ff;
      esum_in   = esum_ff;
      lerr_in   = lerr_ff;
      held_in   = held_ff;
      div_start = 1'b0;
      mac_ctl   = '0;
      mac_gain  = kp_ff;
      mac_operand = OPW'(err_ff);

      rsp_torque_in = rsp_torque_ff;
      rsp_upd_in    = rsp_upd_ff;
      rsp_ratio_in  = rsp_ratio_ff;
      rsp_stop_in   = rsp_stop_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      req_stall = (state_ff != srpid_pkg::ST_IDLE);
      accept    = req_valid && !req_stall;
      front_now = {1'b0, req_front_right_speed} + {1'b0, req_front_left_speed};
      err_now   = $signed({2'b00, target_ff}) - $signed({2'b00, ratio_ff});
      esum_wide = (IB+1)'(err_now) + (IB+1)'(esum_ff);
      q_now     = mac_acc[ACCW-1:FRAC_BITS];

      case (state_ff)
         srpid_pkg::ST_IDLE: begin
            if (accept) begin
               front_in = front_now;
               rear_in  = {1'b0, req_rear_right_speed} + {1'b0, req_rear_left_speed};
               if (!req_drive_active) begin
                  upd_in   = 1'b0;
                  ratio_in = '0;
                  stop_in  = 1'b0;
                  state_in = srpid_pkg::ST_DONE;
               end else if (front_now == '0) begin
                  upd_in   = 1'b1;
                  ratio_in = srpid_pkg::RATIO_MAX;
                  stop_in  = 1'b1;
                  state_in = srpid_pkg::ST_ERROR;
               end else begin
                  upd_in   = 1'b1;
                  stop_in  = 1'b0;
                  state_in = srpid_pkg::ST_DIV_GO;
               end
            end
         end
         srpid_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = srpid_pkg::ST_DIV_WAIT;
         end
         srpid_pkg::ST_DIV_WAIT: begin
            if (div_status.done) begin
               ratio_in = div_ratio;
               state_in = srpid_pkg::ST_ERROR;
            end
         end
         // error, saturating integral, derivative
         srpid_pkg::ST_ERROR: begin
            err_in   = err_now;
            deriv_in = DB'(err_now) - DB'(lerr_ff);
            lerr_in  = err_now;
            if (esum_wide[IB] != esum_wide[IB-1]) begin
               esum_in = esum_wide[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
            end else begin
               esum_in = esum_wide[IB-1:0];
            end
            mac_ctl.clear = 1'b1;
            state_in = srpid_pkg::ST_MUL_P;
         end
         srpid_pkg::ST_MUL_P: begin
            mac_ctl.op_valid = 1'b1;
            mac_gain    = kp_ff;
            mac_operand = OPW'(err_ff);
            state_in    = srpid_pkg::ST_MUL_I;
         end
         srpid_pkg::ST_MUL_I: begin
            mac_ctl.op_valid = 1'b1;
            mac_gain    = ki_ff;
            mac_operand = OPW'(esum_ff);
            state_in    = srpid_pkg::ST_MUL_D;
         end
         srpid_pkg::ST_MUL_D: begin
            mac_ctl.op_valid = 1'b1;
            mac_gain    = kd_ff;
            mac_operand = OPW'(deriv_ff);
            state_in    = srpid_pkg::ST_DRAIN;
         end
         srpid_pkg::ST_DRAIN: begin
            state_in = srpid_pkg::ST_CLAMP;
         end
         // clamp to 0..limit
         srpid_pkg::ST_CLAMP: begin
            if (mac_acc[ACCW-1] || (mac_acc == '0)) begin
               held_in = '0;
            end else if (q_now > QW'(limit_ff)) begin
               held_in = limit_ff;
            end else begin
               held_in = q_now[TB-1:0];
            end
            state_in = srpid_pkg::ST_DONE;
         end
         // hand the result to the output register once it is free
         srpid_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_torque_in = held_ff;
               rsp_upd_in    = upd_ff;
               rsp_ratio_in  = ratio_ff;
               rsp_stop_in   = stop_ff;
               state_in      = srpid_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srpid_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srpid_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         esum_ff      <= '0;
         lerr_ff      <= '0;
         held_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         esum_ff      <= esum_in;
         lerr_ff      <= lerr_in;
         held_ff      <= held_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      rear_ff       <= rear_in;
      ratio_ff      <= ratio_in;
      stop_ff       <= stop_in;
      upd_ff        <= upd_in;
      err_ff        <= err_in;
      deriv_ff      <= deriv_in;
      rsp_torque_ff <= rsp_torque_in;
      rsp_upd_ff    <= rsp_upd_in;
      rsp_ratio_ff  <= rsp_ratio_in;
      rsp_stop_ff   <= rsp_stop_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_torque_adjust = rsp_torque_ff;
   assign rsp_updated       = rsp_upd_ff;
   assign rsp_slip_ratio    = rsp_ratio_ff;
   assign rsp_front_stopped = rsp_stop_ff;

endmodule

// ===== hw/rtl/srpid_div.sv =====
// srpid_div: restoring divider, one quotient bit per cycle, for the slip ratio.
// Depends on srpid_pkg. Result saturates to the 16-bit ratio range.

module srpid_div #(
   parameter int SPEED_BITS = srpid_pkg::SPEED_BITS_DEF,
   parameter int FRAC_BITS  = srpid_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [SPEED_BITS:0]               front_sum,
   input  logic [SPEED_BITS:0]               rear_sum,
   output srpid_pkg::div_status_type         status,
   output logic [srpid_pkg::RATIO_BITS-1:0]  ratio
);

   localparam int DW = SPEED_BITS + 1 + FRAC_BITS;
   localparam int RW = SPEED_BITS + 2;
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0]       num_ff, num_in;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [SPEED_BITS:0] den_ff, den_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [RW-1:0]       trial;
   logic                ge;

   // one shift-and-subtract step
   always_comb begin
      trial  = {rem_ff[RW-2:0], num_ff[DW-1]};
      ge     = (trial >= {1'b0, den_ff});
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = {rear_sum, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = front_sum;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[DW-2:0], ge};
         rem_in = ge ? (trial - {1'b0, den_ff}) : trial;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // saturate quotient to 16 bits
   assign ratio = (|num_ff[DW-1:srpid_pkg::RATIO_BITS]) ? srpid_pkg::RATIO_MAX
                                                        : num_ff[srpid_pkg::RATIO_BITS-1:0];
   assign status.done = done_ff;

endmodule

// ===== hw/rtl/srpid_mac.sv =====
// srpid_mac: shared gain multiplier with registered product and accumulator.
// Depends on srpid_pkg. One product per cycle, added to the accumulator in the following cycle.

module srpid_mac #(
   parameter int OPW = srpid_pkg::INTEGRAL_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  srpid_pkg::mac_ctl_type                 ctl,
   input  logic [srpid_pkg::GAIN_BITS-1:0]        gain,
   input  logic signed [OPW-1:0]                  operand,
   output logic signed [OPW+srpid_pkg::GAIN_BITS+2:0] acc
);

   localparam int PW   = OPW + srpid_pkg::GAIN_BITS + 1;
   localparam int ACCW = OPW + srpid_pkg::GAIN_BITS + 3;

   logic signed [PW-1:0]   prod_ff, prod_in;
   logic                   pvld_ff, pvld_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic signed [srpid_pkg::GAIN_BITS:0] gain_s;

   // multiply, then accumulate the previous product
   always_comb begin
      gain_s  = $signed({1'b0, gain});
      prod_in = gain_s * operand;
      pvld_in = ctl.op_valid;
      acc_in  = pvld_ff ? (acc_ff + ACCW'(prod_ff)) : acc_ff;
      if (ctl.clear) begin
         pvld_in = 1'b0;
         acc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= pvld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule
